// ===== hdl/robin_hood_hash_table_assert.svh =====
// Assertion macros for the hash table block, empty under synthesis
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define RHH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hash table check failed");
`define RHH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hash table invariant failed");
`else
`define RHH_ASSERT(lbl, prop)
`define RHH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/rhh_pkg.sv =====
// Types and constants shared by the hash table modules
package rhh_pkg;
  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned PL_W       = SLOT_W + 1;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = 10;
  localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'(SLOTS / 8 * 7);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [PL_W-1:0]       pl;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;
endpackage

// ===== hdl/rhh_mem.sv =====
// Slot memory: one write port, one registered read port
module rhh_mem (
  input  logic              clk_i,
  input  rhh_pkg::mem_req_t req_i,
  output rhh_pkg::entry_t   rdata_o
);
  import rhh_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/rhh_ctrl.sv =====
// Sequencer: probe walks, swaps, backward shift and clearing sweep
`include "robin_hood_hash_table_assert.svh"
module rhh_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [2:0]                   action_i,
  input  logic [31:0]                  key_i,
  input  logic [31:0]                  hash_value_i,
  input  logic [31:0]                  value_i,
  input  logic [9:0]                   slot_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [9:0]                   slot_index_o,
  output logic [31:0]                  found_key_o,
  output logic [31:0]                  found_value_o,
  output logic                         occupied_o,
  output logic [9:0]                   entry_count_o,
  output rhh_pkg::mem_req_t            req_o,
  input  rhh_pkg::entry_t              rdata_i
);
  import rhh_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_INS, S_LOOK, S_RM0, S_RM, S_RD
  } state_e;

  state_e                state_q, state_d;
  logic [SLOT_W-1:0]     addr_q, addr_d, landed_q, landed_d;
  logic [PL_W-1:0]       pl_q, pl_d;
  logic [KEY_BITS-1:0]   ck_q, ck_d, key_q, key_d;
  logic [VALUE_BITS-1:0] cv_q, cv_d, val_q, val_d;
  logic                  placed_q, placed_d, first_q, first_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q, done_d, occ_q, occ_d;
  status_e               status_q, status_d;
  logic [SLOT_W-1:0]     sidx_q, sidx_d;
  logic [KEY_BITS-1:0]   fkey_q, fkey_d;
  logic [VALUE_BITS-1:0] fval_q, fval_d;
  logic                  accept;
  logic [SLOT_W-1:0]     addr_nx;

  assign accept  = start_i && (state_q == S_IDLE);
  assign addr_nx = addr_q + SLOT_W'(1);

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    landed_d = landed_q;
    pl_d     = pl_q;
    ck_d     = ck_q;
    cv_d     = cv_q;
    key_d    = key_q;
    val_d    = val_q;
    placed_d = placed_q;
    first_d  = first_q;
    count_d  = count_q;
    done_d   = 1'b0;
    occ_d    = occ_q;
    status_d = status_q;
    sidx_d   = sidx_q;
    fkey_d   = fkey_q;
    fval_d   = fval_q;
    req_o.we    = 1'b0;
    req_o.waddr = addr_q;
    req_o.wdata = '{pl: pl_q, key: ck_q, val: cv_q};

    unique case (state_q)
      S_INIT: begin
        // sweep every slot to empty
        req_o.we    = 1'b1;
        req_o.wdata = '0;
        addr_d      = addr_nx;
        if (addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          key_d    = KEY_BITS'(key_i);
          val_d    = VALUE_BITS'(value_i);
          ck_d     = KEY_BITS'(key_i);
          cv_d     = VALUE_BITS'(value_i);
          pl_d     = PL_W'(1);
          placed_d = 1'b0;
          first_d  = 1'b1;
          status_d = ST_OK;
          sidx_d   = '0;
          fkey_d   = '0;
          fval_d   = '0;
          occ_d    = 1'b0;
          unique case (action_i)
            ACT_INSERT: begin
              addr_d = hash_value_i[SLOT_W-1:0];
              if (count_q >= LOAD_LIMIT) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                state_d = S_INS;
              end
            end
            ACT_LOOKUP: begin
              addr_d = hash_value_i[SLOT_W-1:0];
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                state_d = S_LOOK;
              end
            end
            ACT_REMOVE: begin
              addr_d  = slot_i[SLOT_W-1:0];
              sidx_d  = slot_i[SLOT_W-1:0];
              state_d = S_RM0;
            end
            ACT_READ: begin
              addr_d  = slot_i[SLOT_W-1:0];
              sidx_d  = slot_i[SLOT_W-1:0];
              state_d = S_RD;
            end
            ACT_CLEAR: begin
              addr_d  = '0;
              count_d = '0;
              done_d  = 1'b1;
              state_d = S_INIT;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        req_o.wdata = '{pl: pl_q, key: ck_q, val: cv_q};
        if (rdata_i.pl == '0) begin
          req_o.we = 1'b1;
          count_d  = count_q + CNT_W'(1);
          sidx_d   = placed_q ? landed_q : addr_q;
          fkey_d   = key_q;
          fval_d   = val_q;
          occ_d    = 1'b1;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          // swap with a richer resident and carry it onward
          if (pl_q > rdata_i.pl) begin
            req_o.we = 1'b1;
            ck_d     = rdata_i.key;
            cv_d     = rdata_i.val;
            pl_d     = rdata_i.pl + PL_W'(1);
            if (!placed_q) begin
              landed_d = addr_q;
              placed_d = 1'b1;
            end
          end else begin
            pl_d = pl_q + PL_W'(1);
          end
          addr_d = addr_nx;
        end
      end
      S_LOOK: begin
        if (rdata_i.pl >= pl_q && rdata_i.key == key_q) begin
          sidx_d  = addr_q;
          fkey_d  = rdata_i.key;
          fval_d  = rdata_i.val;
          occ_d   = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (rdata_i.pl >= pl_q) begin
          pl_d   = pl_q + PL_W'(1);
          addr_d = addr_nx;
        end else begin
          status_d = ST_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_RM0: begin
        if (rdata_i.pl == '0) begin
          status_d = ST_EMPTY;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          count_d = count_q - CNT_W'(1);
          addr_d  = addr_nx;
          state_d = S_RM;
        end
      end
      S_RM: begin
        // rdata holds the slot after the hole; the hole is addr_q - 1
        req_o.waddr = addr_q - SLOT_W'(1);
        req_o.we    = 1'b1;
        if (rdata_i.pl > PL_W'(1)) begin
          req_o.wdata = '{pl: rdata_i.pl - PL_W'(1), key: rdata_i.key, val: rdata_i.val};
          if (first_q) begin
            fkey_d = rdata_i.key;
            fval_d = rdata_i.val;
            occ_d  = 1'b1;
          end
          first_d = 1'b0;
          addr_d  = addr_nx;
        end else begin
          req_o.wdata = '0;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RD: begin
        if (rdata_i.pl != '0) begin
          fkey_d = rdata_i.key;
          fval_d = rdata_i.val;
          occ_d  = 1'b1;
        end else begin
          status_d = ST_EMPTY;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    req_o.raddr = addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      addr_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      placed_q <= 1'b0;
      first_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      count_q  <= count_d;
      done_q   <= done_d;
      placed_q <= placed_d;
      first_q  <= first_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    landed_q <= landed_d;
    pl_q     <= pl_d;
    ck_q     <= ck_d;
    cv_q     <= cv_d;
    key_q    <= key_d;
    val_q    <= val_d;
    occ_q    <= occ_d;
    sidx_q   <= sidx_d;
    fkey_q   <= fkey_d;
    fval_q   <= fval_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_index_o  = 10'(sidx_q);
  assign found_key_o   = 32'(fkey_q);
  assign found_value_o = 32'(fval_q);
  assign occupied_o    = occ_q;
  assign entry_count_o = 10'(count_q);

  `RHH_ASSERT_ALWAYS(a_count_limit, count_q <= LOAD_LIMIT)
  `RHH_ASSERT(a_no_write_idle, state_q == S_IDLE |-> !req_o.we)
  `RHH_ASSERT(a_full_at_limit, done_q && status_q == ST_FULL |-> count_q == LOAD_LIMIT)
  `RHH_ASSERT(a_accept_moves, accept |=> (state_q != S_IDLE) || done_q)
endmodule

// ===== hdl/robin_hood_hash_table.sv =====
// Robin Hood hash table top level: sequencer and slot memory
//
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// action   | start, busy         | action_i key_i hash_value_i value_i slot_i
// result   | done_o (one cycle)  | status_o slot_index_o found_key_o
//          |                     | found_value_o occupied_o entry_count_o
//
// An item is taken when start is high and busy is low; one result follows.
// Insert and lookup walk the probe run slot by slot, remove shifts entries
// back slot by slot; one read and one write of the slot memory per cycle sets
// the pace. Insert on a full table and lookup on an empty one need no walk.
// After reset and after clear, busy stays high while the probe lengths are
// swept to zero. The receiver cannot stall.
module robin_hood_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] hash_value_i,
  input  logic [31:0] value_i,
  input  logic [9:0]  slot_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [9:0]  slot_index_o,
  output logic [31:0] found_key_o,
  output logic [31:0] found_value_o,
  output logic        occupied_o,
  output logic [9:0]  entry_count_o
);
  import rhh_pkg::*;

  mem_req_t req;
  entry_t   rdata;

  rhh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .action_i      (action_i),
    .key_i         (key_i),
    .hash_value_i  (hash_value_i),
    .value_i       (value_i),
    .slot_i        (slot_i),
    .busy_o        (busy),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o),
    .occupied_o    (occupied_o),
    .entry_count_o (entry_count_o),
    .req_o         (req),
    .rdata_i       (rdata)
  );

  rhh_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );
endmodule

// ===== verif/tb_robin_hood_hash_table.sv =====
// Self-checking testbench for the Robin Hood hash table: directed, fill and churn tests
`timescale 1ns / 100ps

module tb_robin_hood_hash_table;
  import rhh_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic        occupied;
    logic [9:0]  entry_count;
  } outcome_t;

  localparam int CYCLE_LIMIT = 5000000;

  logic        clk_i, rst_ni, start, busy;
  logic [2:0]  action_i;
  logic [31:0] key_i, hash_value_i, value_i;
  logic [9:0]  slot_i;
  logic        done_o, occupied_o;
  logic [1:0]  status_o;
  logic [9:0]  slot_index_o, entry_count_o;
  logic [31:0] found_key_o, found_value_o;

  robin_hood_hash_table DUT (.*);

  // shadow copy of the table
  int unsigned    probe_len [SLOTS];
  logic [31:0]    slot_key [SLOTS];
  logic [31:0]    slot_val [SLOTS];
  int unsigned    live_count;
  outcome_t       pending_outcomes[$];
  int             mismatches, checked, cycles, sent;
  int             full_refusals, shifts_seen;
  bit             no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles,
               pending_outcomes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic outcome_t slot_report(status_e st, logic [9:0] idx);
    outcome_t o;
    o = '0;
    o.status = st;
    o.slot_index = idx;
    if (probe_len[idx] != 0 && st != ST_FULL && st != ST_NOT_FOUND) begin
      o.found_key = slot_key[idx];
      o.found_value = slot_val[idx];
      o.occupied = 1'b1;
    end
    o.entry_count = live_count[9:0];
    return o;
  endfunction

  // apply one accepted item to the shadow table and queue its outcome
  function automatic void predict_outcome(logic [2:0] act, logic [31:0] k,
                                          logic [31:0] h, logic [31:0] v,
                                          logic [9:0] s);
    outcome_t    o;
    logic [9:0]  b, landed, cur, nxt;
    int unsigned p, tp;
    logic [31:0] ck, cv, tk, tv;
    bit          placed;
    o = '0;
    o.entry_count = live_count[9:0];
    case (act)
      ACT_INSERT: begin
        if (live_count + 1 > LOAD_LIMIT) begin
          o.status = ST_FULL;
          full_refusals++;
        end else begin
          b = h[9:0]; p = 1; ck = k; cv = v; placed = 0; landed = '0;
          while (probe_len[b] != 0) begin
            if (p > probe_len[b]) begin
              tp = probe_len[b]; probe_len[b] = p; p = tp;
              tk = slot_key[b]; slot_key[b] = ck; ck = tk;
              tv = slot_val[b]; slot_val[b] = cv; cv = tv;
              if (!placed) begin
                landed = b; placed = 1;
              end
            end
            b = b + 1'b1;
            p++;
          end
          probe_len[b] = p; slot_key[b] = ck; slot_val[b] = cv;
          if (!placed) landed = b;
          live_count++;
          o = slot_report(ST_OK, landed);
        end
      end
      ACT_LOOKUP: begin
        o.status = ST_NOT_FOUND;
        if (live_count != 0) begin
          b = h[9:0]; p = 1;
          while (probe_len[b] >= p && slot_key[b] != k) begin
            b = b + 1'b1;
            p++;
          end
          if (probe_len[b] >= p) o = slot_report(ST_OK, b);
        end
      end
      ACT_REMOVE: begin
        if (probe_len[s] == 0) begin
          o = slot_report(ST_EMPTY, s);
        end else begin
          live_count--;
          cur = s; nxt = s + 1'b1;
          while (probe_len[nxt] > 1) begin
            probe_len[cur] = probe_len[nxt] - 1;
            slot_key[cur] = slot_key[nxt];
            slot_val[cur] = slot_val[nxt];
            cur = nxt; nxt = cur + 1'b1;
            shifts_seen++;
          end
          probe_len[cur] = 0;
          o = slot_report(ST_OK, s);
        end
      end
      ACT_READ: o = slot_report(probe_len[s] != 0 ? ST_OK : ST_EMPTY, s);
      ACT_CLEAR: begin
        foreach (probe_len[i]) probe_len[i] = 0;
        live_count = 0;
        o.entry_count = '0;
      end
      default: ;
    endcase
    pending_outcomes.push_back(o);
  endfunction

  // send one item, wait until the table is no longer busy, then predict
  task automatic send_item(logic [2:0] act, logic [31:0] k, logic [31:0] h,
                           logic [31:0] v, logic [9:0] s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act; key_i <= k; hash_value_i <= h; value_i <= v; slot_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_outcome(act, k, h, v, s);
    sent++;
    if ($urandom_range(0, 60) == 0) no_gaps = ~no_gaps;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      outcome_t got, want;
      got = {status_o, slot_index_o, found_key_o, found_value_o, occupied_o,
             entry_count_o};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        checked++;
        if (got.status != want.status || got.slot_index != want.slot_index ||
            got.found_key != want.found_key || got.found_value != want.found_value ||
            got.occupied != want.occupied || got.entry_count != want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at result %0d: expected %p, got %p", checked, want, got);
        end
      end
    end
  end

  function automatic logic [9:0] pick_occupied();
    logic [9:0] s;
    s = 10'($urandom_range(0, SLOTS - 1));
    if (live_count == 0) return s;
    while (probe_len[s] == 0) s = s + 1'b1;
    return s;
  endfunction

  // look up the key held at an occupied slot using its home slot
  task automatic lookup_held(logic [9:0] s);
    logic [9:0] home;
    home = s - 10'(probe_len[s] - 1);
    send_item(ACT_LOOKUP, slot_key[s], {22'($urandom_range(0, 22'h3FFFFF)), home},
              $urandom, 10'($urandom));
  endtask

  task automatic test_directed();
    send_item(ACT_LOOKUP, 32'h1234, 32'h5, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 10'd0);
    send_item(ACT_READ, 0, 0, 0, 10'h3FF);
    send_item(ACT_REMOVE, 0, 0, 0, 10'h3FF);
    send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(ACT_INSERT, 32'h0, 32'h0000_03FF, 32'h0, 10'h3FF);
    send_item(ACT_INSERT, 32'hA5A5_5A5A, 32'hFFFF_FBFF, 32'h1, 0);
    send_item(ACT_INSERT, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 0);
    send_item(ACT_INSERT, 32'hA5A5_5A5A, 32'h0000_03FF, 32'h2, 0);   // duplicate key
    send_item(ACT_LOOKUP, 32'hA5A5_5A5A, 32'h0000_03FF, 0, 0);
    send_item(ACT_LOOKUP, 32'h0000_0001, 32'h0, 0, 0);
    send_item(ACT_LOOKUP, 32'hDEAD_BEEF, 32'h0000_03FF, 0, 0);
    send_item(ACT_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0200, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 10'd1);
    send_item(ACT_REMOVE, 0, 0, 0, 10'h3FF);                         // shift back across wrap
    send_item(ACT_READ, 0, 0, 0, 10'h3FF);
    send_item(ACT_READ, 0, 0, 0, 10'd0);
    send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_item(3'd6, 0, 0, 0, 0);
    send_item(3'd7, 0, 0, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 10'd0);
    send_item(ACT_LOOKUP, 32'h0000_0001, 32'h0, 0, 0);
  endtask

  // fill to the load limit, then push past it
  task automatic test_fill_to_limit();
    send_item(ACT_CLEAR, $urandom, $urandom, $urandom, 10'($urandom));
    while (live_count < LOAD_LIMIT) begin
      if ($urandom_range(0, 9) == 0 && live_count != 0) lookup_held(pick_occupied());
      else send_item(ACT_INSERT, $urandom, $urandom, $urandom, 10'($urandom));
    end
    repeat (6) send_item(ACT_INSERT, $urandom, $urandom, $urandom, 10'($urandom));
    repeat (10) lookup_held(pick_occupied());
    repeat (4) send_item(ACT_LOOKUP, $urandom, $urandom, 0, 0);
    repeat (10) send_item(ACT_REMOVE, 0, 0, 0, pick_occupied());
  endtask

  // mixed traffic with clustered home slots to build long probe runs
  task automatic test_churn(int n);
    int r;
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_item(ACT_INSERT, $urandom_range(0, 40) == 0 ? 32'h55 : $urandom,
                  base + $urandom_range(0, 24), $urandom, 10'($urandom));
      else if (r < 55 && live_count != 0) lookup_held(pick_occupied());
      else if (r < 62)
        send_item(ACT_LOOKUP, $urandom, base + $urandom_range(0, 24), 0, 0);
      else if (r < 80) send_item(ACT_REMOVE, $urandom, $urandom, $urandom, pick_occupied());
      else if (r < 85) send_item(ACT_REMOVE, 0, 0, 0, 10'($urandom));
      else if (r < 95)
        send_item(ACT_READ, $urandom, $urandom, $urandom, 10'($urandom));
      else if (r < 98)
        send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                  10'($urandom));
      else begin
        send_item(ACT_CLEAR, $urandom, $urandom, $urandom, 10'($urandom));
        base = $urandom;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0; start = 1'b0;
    action_i = '0; key_i = '0; hash_value_i = '0; value_i = '0; slot_i = '0;
    mismatches = 0; checked = 0; cycles = 0; sent = 0;
    full_refusals = 0; shifts_seen = 0; no_gaps = 0; live_count = 0;
    foreach (probe_len[i]) begin
      probe_len[i] = 0; slot_key[i] = '0; slot_val[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_to_limit();
    test_churn(300);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items (%0d results checked) over %0d cycles,", sent, checked,
             cycles);
    $display("with %0d full-table refusals and %0d backward shifts.", full_refusals,
             shifts_seen);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/rhh_pkg.sv
hdl/rhh_mem.sv
hdl/rhh_ctrl.sv
hdl/robin_hood_hash_table.sv
verif/tb_robin_hood_hash_table.sv
